@@ rtl/core/sjfs_pkg.sv @@
// ----------------------------------------------------------------------------
// sjfs_pkg
// Shared types, sizes and the key compare of the shortest-job-first scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package sjfs_pkg;

  // job store sizing
  localparam int MAX_JOBS = 64;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);

  // fixed field widths
  localparam int TIME_IN_W = 16;
  localparam int JOB_W     = 7;
  localparam int CLOCK_W   = 23;
  localparam int WAIT_W    = 22;
  localparam int SUM_W     = 28;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED_SCAN,
    ST_SCHED_APPLY,
    ST_EMIT_SCAN,
    ST_EMIT_READ,
    ST_EMIT_LOAD,
    ST_EMIT_HOLD
  } sjfs_state_t;

  // two-level key compare: (hi_a, lo_a) strictly before (hi_b, lo_b)
  function automatic logic key_less(input logic [TIME_IN_W-1:0] hi_a,
                                    input logic [TIME_IN_W-1:0] lo_a,
                                    input logic [TIME_IN_W-1:0] hi_b,
                                    input logic [TIME_IN_W-1:0] lo_b);
    logic res;
    res = (hi_a < hi_b) || ((hi_a == hi_b) && (lo_a < lo_b));
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sjf_nonpreemptive_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// sjf_nonpreemptive_scheduler_unit
// Collects a set of jobs, runs non-preemptive shortest-job-first over them and
// reports per-job waiting and turnaround times in arrival order.
// ----------------------------------------------------------------------------
// Each job item is taken and stored; up to MAX_JOBS jobs are kept and further
// jobs are dropped. The item with last_job set starts the run and the block
// then holds in_stall high until the last result has been taken.
// All work goes through one scan over the job memory with a registered read
// and one shared key comparator: every scheduling decision is a scan followed
// by an update step, and a decision that finds no arrived job makes time jump
// to the earliest pending arrival and scans again (at most n extra scans for
// n jobs). Every result is another scan in output order, then the stored wait
// is read, the output register is loaded and the result is presented, held
// there while out_stall is high. Totals are zero except on the last result.
`default_nettype none

module sjf_nonpreemptive_scheduler_unit
  import sjfs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // job items
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [TIME_IN_W-1:0] in_arrival_time,
  input  wire logic [TIME_IN_W-1:0] in_burst_time,
  input  wire logic                 in_last_job,
  // result items
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [JOB_W-1:0]          out_job_number,
  output logic [WAIT_W-1:0]         out_waiting_time,
  output logic [WAIT_W-1:0]         out_turnaround_time,
  output logic [SUM_W-1:0]          out_total_waiting,
  output logic [SUM_W-1:0]          out_total_turnaround,
  output logic                      out_last_result
);

  // job memories
  logic [TIME_IN_W-1:0] arrival_mem [MAX_JOBS];
  logic [TIME_IN_W-1:0] burst_mem   [MAX_JOBS];
  logic [CLOCK_W-1:0]   wait_mem    [MAX_JOBS];

  sjfs_state_t state_r, state_nxt;

  logic [CNT_W-1:0]     job_cnt_r;
  logic [CNT_W-1:0]     sched_cnt_r;
  logic [CNT_W-1:0]     emit_cnt_r;
  logic [CNT_W-1:0]     issue_r;
  logic                 p_vld_r;
  logic [IDX_W-1:0]     p_idx_r;
  logic [MAX_JOBS-1:0]  done_r;

  logic [TIME_IN_W-1:0] arr_q_r, bur_q_r;
  logic [CLOCK_W-1:0]   wait_q_r;

  logic [CLOCK_W-1:0]   time_r;
  logic [SUM_W-1:0]     wsum_r, tsum_r;

  logic                 found_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [TIME_IN_W-1:0] best_a_r, best_b_r;
  logic                 any_r;
  logic [TIME_IN_W-1:0] earliest_r;

  logic                 out_valid_r;
  logic [JOB_W-1:0]     out_job_r;
  logic [WAIT_W-1:0]    out_wait_r, out_turn_r;
  logic [SUM_W-1:0]     out_twait_r, out_tturn_r;
  logic                 out_last_r;

  logic                 in_acc, out_acc;
  logic                 scanning, emit_mode, scan_end;
  logic                 issue_go;
  logic [IDX_W-1:0]     rd_addr;
  logic                 p_done;
  logic [TIME_IN_W-1:0] cmp_hi_a, cmp_lo_a, cmp_hi_b, cmp_lo_b;
  logic                 cmp_less;
  logic                 take_sched, take_emit, take_best;
  logic [CLOCK_W-1:0]   new_wait;
  logic [CLOCK_W-1:0]   emit_turn;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;

  // scan control
  assign scanning  = (state_r == ST_SCHED_SCAN) || (state_r == ST_EMIT_SCAN);
  assign emit_mode = (state_r == ST_EMIT_SCAN);
  assign issue_go  = scanning && (issue_r != job_cnt_r);
  assign scan_end  = scanning && (issue_r == job_cnt_r) && !p_vld_r;
  assign rd_addr   = issue_r[IDX_W-1:0];
  assign p_done    = done_r[p_idx_r];

  // shared key comparator: (burst, arrival) when scheduling, swapped when emitting
  assign cmp_hi_a = emit_mode ? arr_q_r  : bur_q_r;
  assign cmp_lo_a = emit_mode ? bur_q_r  : arr_q_r;
  assign cmp_hi_b = emit_mode ? best_a_r : best_b_r;
  assign cmp_lo_b = emit_mode ? best_b_r : best_a_r;
  assign cmp_less = key_less(cmp_hi_a, cmp_lo_a, cmp_hi_b, cmp_lo_b);

  // candidate selection
  assign take_sched = (state_r == ST_SCHED_SCAN) && p_vld_r && !p_done &&
                      (CLOCK_W'(arr_q_r) <= time_r) && (!found_r || cmp_less);
  assign take_emit  = emit_mode && p_vld_r && p_done && (!found_r || cmp_less);
  assign take_best  = take_sched || take_emit;

  assign new_wait  = time_r - CLOCK_W'(best_a_r);
  assign emit_turn = wait_q_r + CLOCK_W'(best_b_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_last_job) state_nxt = ST_SCHED_SCAN;
      end
      ST_SCHED_SCAN: begin
        if (scan_end) state_nxt = ST_SCHED_APPLY;
      end
      ST_SCHED_APPLY: begin
        if (found_r && (sched_cnt_r + CNT_W'(1) == job_cnt_r)) state_nxt = ST_EMIT_SCAN;
        else state_nxt = ST_SCHED_SCAN;
      end
      ST_EMIT_SCAN: begin
        if (scan_end) state_nxt = ST_EMIT_READ;
      end
      ST_EMIT_READ: state_nxt = ST_EMIT_LOAD;
      ST_EMIT_LOAD: state_nxt = ST_EMIT_HOLD;
      ST_EMIT_HOLD: begin
        if (out_acc) state_nxt = out_last_r ? ST_IDLE : ST_EMIT_SCAN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // job memories: write on store, registered read for the scan
  always_ff @(posedge clk) begin
    if (in_acc && (job_cnt_r != CNT_W'(MAX_JOBS))) begin
      arrival_mem[job_cnt_r[IDX_W-1:0]] <= in_arrival_time;
      burst_mem[job_cnt_r[IDX_W-1:0]]   <= in_burst_time;
    end
    arr_q_r <= arrival_mem[rd_addr];
    bur_q_r <= burst_mem[rd_addr];
  end

  // wait memory: written per scheduled job, read at the selected job
  always_ff @(posedge clk) begin
    if ((state_r == ST_SCHED_APPLY) && found_r) wait_mem[best_idx_r] <= new_wait;
    wait_q_r <= wait_mem[best_idx_r];
  end

  // scan pipeline and control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_cnt_r   <= '0;
      sched_cnt_r <= '0;
      emit_cnt_r  <= '0;
      issue_r     <= '0;
      p_vld_r     <= 1'b0;
      done_r      <= '0;
      found_r     <= 1'b0;
      any_r       <= 1'b0;
      time_r      <= '0;
      wsum_r      <= '0;
      tsum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      p_vld_r <= issue_go;
      if (issue_go) issue_r <= issue_r + CNT_W'(1);

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (job_cnt_r != CNT_W'(MAX_JOBS))) job_cnt_r <= job_cnt_r + CNT_W'(1);
        end
        ST_SCHED_SCAN, ST_EMIT_SCAN: begin
          if (take_best) found_r <= 1'b1;
          // earliest pending arrival for the idle jump
          if ((state_r == ST_SCHED_SCAN) && p_vld_r && !p_done) begin
            any_r <= 1'b1;
            if (!any_r || (arr_q_r < earliest_r)) earliest_r <= arr_q_r;
          end
        end
        ST_SCHED_APPLY: begin
          issue_r <= '0;
          found_r <= 1'b0;
          any_r   <= 1'b0;
          if (found_r) begin
            done_r[best_idx_r] <= 1'b1;
            sched_cnt_r        <= sched_cnt_r + CNT_W'(1);
            time_r             <= time_r + CLOCK_W'(best_b_r);
            wsum_r             <= wsum_r + SUM_W'(new_wait);
            tsum_r             <= tsum_r + SUM_W'(new_wait) + SUM_W'(best_b_r);
          end else begin
            time_r <= CLOCK_W'(earliest_r);
          end
        end
        ST_EMIT_READ: ;
        ST_EMIT_LOAD: begin
          out_valid_r        <= 1'b1;
          done_r[best_idx_r] <= 1'b0;
          emit_cnt_r         <= emit_cnt_r + CNT_W'(1);
          issue_r            <= '0;
          found_r            <= 1'b0;
        end
        ST_EMIT_HOLD: begin
          if (out_acc) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              job_cnt_r   <= '0;
              sched_cnt_r <= '0;
              emit_cnt_r  <= '0;
              time_r      <= '0;
              wsum_r      <= '0;
              tsum_r      <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // best candidate payload
  always_ff @(posedge clk) begin
    if (take_best) begin
      best_idx_r <= p_idx_r;
      best_a_r   <= arr_q_r;
      best_b_r   <= bur_q_r;
    end
    p_idx_r <= rd_addr;
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT_LOAD) begin
      out_job_r   <= JOB_W'(best_idx_r) + JOB_W'(1);
      out_wait_r  <= wait_q_r[WAIT_W-1:0];
      out_turn_r  <= emit_turn[WAIT_W-1:0];
      out_last_r  <= (emit_cnt_r + CNT_W'(1) == job_cnt_r);
      out_twait_r <= (emit_cnt_r + CNT_W'(1) == job_cnt_r) ? wsum_r : '0;
      out_tturn_r <= (emit_cnt_r + CNT_W'(1) == job_cnt_r) ? tsum_r : '0;
    end
  end

  assign in_stall             = (state_r != ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_job_number       = out_job_r;
  assign out_waiting_time     = out_wait_r;
  assign out_turnaround_time  = out_turn_r;
  assign out_total_waiting    = out_twait_r;
  assign out_total_turnaround = out_tturn_r;
  assign out_last_result      = out_last_r;

  // no job item is taken while a result is pending
  assert property (@(posedge clk) disable iff (!rst_n) !(in_acc && out_valid_r))
    else $error("job item accepted while a result is pending");

  // the job count never exceeds the store depth
  assert property (@(posedge clk) disable iff (!rst_n) job_cnt_r <= CNT_W'(MAX_JOBS))
    else $error("job count beyond store depth");

  // a scheduled job has always arrived
  assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCHED_APPLY) && found_r) |-> (CLOCK_W'(best_a_r) <= time_r))
    else $error("scheduled job has not arrived");

  // the run is cleared once the last result is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last_r) |=> ((job_cnt_r == '0) && (done_r == '0)))
    else $error("run not cleared after last result");

endmodule

`default_nettype wire
